### hw/rtl/pwf_pkg.sv
// Shared constants, codes and the arctangent table of the waypoint follower.
package pwf_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int CORDIC_STEPS  = 16;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);

  localparam int CX_W = 44;  // CORDIC x and y
  localparam int Z_W  = 29;  // CORDIC angle, Q.24 radians

  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 29'sd26353589;
  localparam logic signed [Z_W:0]   PI_Q24      = 30'sd52707179;
  localparam logic signed [Z_W:0]   TWO_PI_Q24  = 30'sd105414357;
  localparam logic [15:0]           INV_GAIN    = 16'd39797;

  localparam logic [1:0] OP_NEW_PATH = 2'd0;
  localparam logic [1:0] OP_STORE    = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic [2:0] REG_LIN_P  = 3'd0;
  localparam logic [2:0] REG_LIN_I  = 3'd1;
  localparam logic [2:0] REG_LIN_D  = 3'd2;
  localparam logic [2:0] REG_ANG_P  = 3'd3;
  localparam logic [2:0] REG_ANG_I  = 3'd4;
  localparam logic [2:0] REG_ANG_D  = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;
  localparam logic [2:0] REG_SMOOTH = 3'd7;

  localparam logic signed [12:0] TURN_WIDE   = 13'sd2458;
  localparam logic signed [12:0] TURN_NARROW = 13'sd2048;

  // atan(2^-i) in Q.24 radians.
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = 29'sd13176795;
      5'd1:  v = 29'sd7778716;
      5'd2:  v = 29'sd4110060;
      5'd3:  v = 29'sd2086331;
      5'd4:  v = 29'sd1047214;
      5'd5:  v = 29'sd524117;
      5'd6:  v = 29'sd262123;
      5'd7:  v = 29'sd131069;
      5'd8:  v = 29'sd65536;
      5'd9:  v = 29'sd32768;
      5'd10: v = 29'sd16384;
      5'd11: v = 29'sd8192;
      5'd12: v = 29'sd4096;
      5'd13: v = 29'sd2048;
      5'd14: v = 29'sd1024;
      5'd15: v = 29'sd512;
      5'd16: v = 29'sd256;
      5'd17: v = 29'sd128;
      5'd18: v = 29'sd64;
      5'd19: v = 29'sd32;
      5'd20: v = 29'sd16;
      5'd21: v = 29'sd8;
      5'd22: v = 29'sd4;
      5'd23: v = 29'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/pwf_ram.sv
// Generic single-port-write, registered-read RAM.
module pwf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/pid_waypoint_follower.sv
// Top level of the waypoint follower: path table, CORDIC, two PID loops and speed smoothing.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | operation, count, waypoint, robot pose
//   out_    | output    | out_valid/out_stall | linear speed, turn rate, stop, waypoint index
//   cfg_    | input     | cfg_write_en        | register index and data
//
// Store and new-path words are taken in the idle state; an empty path also emits a stop word.
// A control tick runs through acceptance, one RAM read, CORDIC_STEPS shift-add
// iterations, the shared multiplier in S_DIST and S_DIST2 for the distance, the arrival check,
// the multiplier slots for both PID loops, the scaling and the smoothing, and the emit.
// A reached waypoint ends the tick at the arrival check, plus the emit for a stop at the goal.
// Reset is synchronous; the emit waits while a stalled result fills the output register.
module pid_waypoint_follower (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [6:0]         in_point_count,
  input  logic signed [31:0] in_waypoint_x,
  input  logic signed [31:0] in_waypoint_y,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [15:0] in_robot_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        out_linear_speed,
  output logic signed [12:0] out_angular_rate,
  output logic               out_stop_issued,
  output logic [6:0]         out_current_waypoint,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_ROT    = 4'd2;
  localparam logic [3:0] S_DIST   = 4'd3;
  localparam logic [3:0] S_DIST2  = 4'd4;
  localparam logic [3:0] S_ARRIVE = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  localparam int AW = pwf_pkg::ADDR_W;
  localparam int CW = pwf_pkg::CNT_W;
  localparam int XW = pwf_pkg::CX_W;
  localparam int ZW = pwf_pkg::Z_W;
  localparam int SW = pwf_pkg::STEP_W;

  logic [3:0] state_r;
  logic [CW-1:0] path_len_r, follow_r, wptr_r;
  logic signed [47:0] lsum_r;
  logic signed [31:0] llast_r, asum_r;
  logic signed [15:0] alast_r;
  logic [15:0] smooth_r;

  logic [15:0] lin_p_r, lin_i_r, lin_d_r, ang_p_r, ang_i_r, ang_d_r;
  logic [19:0] radius_r;
  logic [16:0] weight_r;

  logic signed [31:0] rx_r, ry_r;
  logic signed [15:0] yaw_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic zero_r;
  logic [SW-1:0] step_r;
  logic [33:0] dist_r;
  logic signed [15:0] ae_r;
  logic signed [16:0] aderiv_r;
  logic signed [32:0] lderiv_r;
  logic [31:0] le_r;
  logic [13:0] scale_r;
  logic [3:0] mcnt_r;
  logic signed [66:0] acc_r, prod_r;
  logic signed [40:0] ang_r;
  logic signed [41:0] lin_r;
  logic [10:0] linq_r;
  logic signed [12:0] angq_r;
  logic [10:0] res_lin_r;
  logic signed [12:0] res_ang_r;
  logic res_stop_r;
  logic out_valid_r;

  logic accept;
  logic ram_we;
  logic [31:0] ram_x, ram_y;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign ram_we    = accept && (in_operation == pwf_pkg::OP_STORE) && (wptr_r < path_len_r);

  pwf_ram #(.WIDTH(32), .DEPTH(pwf_pkg::MAX_WAYPOINTS)) u_ram_x (
    .clk(clk), .wr_en(ram_we), .wr_addr(wptr_r[AW-1:0]), .wr_data(in_waypoint_x),
    .rd_addr(follow_r[AW-1:0]), .rd_data(ram_x)
  );
  pwf_ram #(.WIDTH(32), .DEPTH(pwf_pkg::MAX_WAYPOINTS)) u_ram_y (
    .clk(clk), .wr_en(ram_we), .wr_addr(wptr_r[AW-1:0]), .wr_data(in_waypoint_y),
    .rd_addr(follow_r[AW-1:0]), .rd_data(ram_y)
  );

  // Coordinate differences, scaled by 256 for the CORDIC.
  logic signed [32:0] dx, dy;
  logic signed [XW-1:0] x0, y0;
  assign dx = $signed({ram_x[31], ram_x}) - $signed({rx_r[31], rx_r});
  assign dy = $signed({ram_y[31], ram_y}) - $signed({ry_r[31], ry_r});
  assign x0 = $signed({{(XW-41){dx[32]}}, dx, 8'b0});
  assign y0 = $signed({{(XW-41){dy[32]}}, dy, 8'b0});

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atan_v;
  assign xs     = cx_r >>> step_r;
  assign ys     = cy_r >>> step_r;
  assign atan_v = pwf_pkg::atan_q24(5'(step_r));

  // Heading error wrapped into (-pi, pi]; one correction covers the whole range.
  logic signed [ZW:0] err_raw, err_w, err_rnd;
  logic signed [ZW-1:0] z_use;
  assign z_use   = zero_r ? '0 : cz_r;
  assign err_raw = $signed({z_use[ZW-1], z_use}) - $signed({{2{yaw_r[15]}}, yaw_r, 11'b0});
  always_comb begin
    if (err_raw > pwf_pkg::PI_Q24) begin
      err_w = err_raw - pwf_pkg::TWO_PI_Q24;
    end else if (err_raw <= -pwf_pkg::PI_Q24) begin
      err_w = err_raw + pwf_pkg::TWO_PI_Q24;
    end else begin
      err_w = err_raw;
    end
  end
  assign err_rnd = (err_w + 30'sd1024) >>> 11;

  logic [14:0] absae;
  assign absae = ae_r[15] ? 15'(-ae_r) : 15'(ae_r);

  // Updates done at the arrival check.
  logic signed [32:0] asum_add;
  logic signed [48:0] lsum_add;
  logic [31:0] le_c;
  logic signed [15:0] turn_c;
  logic [13:0] turn_s, goal_s;
  assign asum_add = $signed({asum_r[31], asum_r}) + $signed({{17{ae_r[15]}}, ae_r});
  assign le_c     = (dist_r[33:31] != 3'b0) ? 32'h7FFF_FFFF : dist_r[31:0];
  assign lsum_add = $signed({lsum_r[47], lsum_r}) + $signed({17'b0, le_c});
  assign turn_c   = 16'sd8192 - $signed({1'b0, absae});
  assign turn_s   = (turn_c < 16'sd819) ? 14'd819 : 14'(turn_c);
  assign goal_s   = (dist_r >= 34'd32768) ? 14'd8192 : {1'b0, dist_r[14:2]};

  // Shared multiplier operands, chosen by the state and the slot counter.
  logic [16:0] w_eff;
  logic signed [48:0] ma;
  logic signed [17:0] mb;
  assign w_eff = (weight_r[16] && weight_r[15:0] != 16'b0) ? 17'd65536 : weight_r;
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == S_DIST) begin
      ma = $signed({{(49-XW){cx_r[XW-1]}}, cx_r});
      mb = $signed({2'b0, pwf_pkg::INV_GAIN});
    end else if (state_r == S_MUL) begin
      unique case (mcnt_r)
        4'd0: begin ma = 49'(ae_r);     mb = $signed({2'b0, ang_p_r}); end
        4'd1: begin ma = 49'(asum_r);   mb = $signed({2'b0, ang_i_r}); end
        4'd2: begin ma = 49'(aderiv_r); mb = $signed({2'b0, ang_d_r}); end
        4'd3: begin ma = $signed({17'b0, le_r}); mb = $signed({2'b0, lin_p_r}); end
        4'd4: begin ma = 49'(lsum_r);   mb = $signed({2'b0, lin_i_r}); end
        4'd5: begin ma = 49'(lderiv_r); mb = $signed({2'b0, lin_d_r}); end
        4'd7: begin ma = 49'(lin_r);    mb = $signed({4'b0, scale_r}); end
        4'd9: begin ma = $signed({38'b0, linq_r}); mb = $signed({1'b0, w_eff}); end
        4'd10: begin
          ma = $signed({33'b0, smooth_r});
          mb = $signed({1'b0, 17'd65536 - w_eff});
        end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  logic signed [66:0] prod_c, sum_c, ip_c, lin_c, linq_c;
  logic [31:0] sm_c;
  assign prod_c = ma * mb;
  assign sum_c  = acc_r + prod_r;
  always_comb begin
    if (prod_r > 67'sd2305843009213693952) begin
      ip_c = 67'sd2305843009213693952;
    end else if (prod_r < -67'sd2305843009213693952) begin
      ip_c = -67'sd2305843009213693952;
    end else begin
      ip_c = prod_r;
    end
    if (sum_c > 67'sd1099511627776) begin
      lin_c = 67'sd1099511627776;
    end else if (sum_c < -67'sd1099511627776) begin
      lin_c = -67'sd1099511627776;
    end else begin
      lin_c = sum_c;
    end
  end
  assign linq_c = (prod_r + 67'sd268435456) >>> 29;
  assign sm_c   = 32'(sum_c + 67'sd32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      path_len_r  <= '0;
      follow_r    <= '0;
      wptr_r      <= '0;
      lsum_r      <= '0;
      llast_r     <= '0;
      asum_r      <= '0;
      alast_r     <= '0;
      smooth_r    <= '0;
      lin_p_r     <= 16'd7373;
      lin_i_r     <= 16'd0;
      lin_d_r     <= 16'd410;
      ang_p_r     <= 16'd4096;
      ang_i_r     <= 16'd0;
      ang_d_r     <= 16'd410;
      radius_r    <= 20'd6554;
      weight_r    <= 17'd19661;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      mcnt_r      <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          pwf_pkg::REG_LIN_P:  lin_p_r  <= cfg_data[15:0];
          pwf_pkg::REG_LIN_I:  lin_i_r  <= cfg_data[15:0];
          pwf_pkg::REG_LIN_D:  lin_d_r  <= cfg_data[15:0];
          pwf_pkg::REG_ANG_P:  ang_p_r  <= cfg_data[15:0];
          pwf_pkg::REG_ANG_I:  ang_i_r  <= cfg_data[15:0];
          pwf_pkg::REG_ANG_D:  ang_d_r  <= cfg_data[15:0];
          pwf_pkg::REG_RADIUS: radius_r <= cfg_data;
          pwf_pkg::REG_SMOOTH: weight_r <= cfg_data[16:0];
          default: ;
        endcase
      end

      // The emit state loads the output register itself.
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_operation == pwf_pkg::OP_NEW_PATH) begin
              path_len_r <= (in_point_count > CW'(pwf_pkg::MAX_WAYPOINTS)) ?
                            CW'(pwf_pkg::MAX_WAYPOINTS) : in_point_count;
              follow_r   <= '0;
              wptr_r     <= '0;
              if (in_point_count == 7'd0) begin
                state_r <= S_EMIT;
              end
            end else if (in_operation == pwf_pkg::OP_STORE) begin
              if (wptr_r < path_len_r) begin
                wptr_r <= wptr_r + 1'b1;
              end
            end else if (in_operation == pwf_pkg::OP_TICK) begin
              if (path_len_r != '0 && follow_r < path_len_r) begin
                state_r <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          step_r  <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          step_r <= step_r + 1'b1;
          if (step_r == SW'(pwf_pkg::CORDIC_STEPS - 1)) begin
            state_r <= S_DIST;
          end
        end
        S_DIST:  state_r <= S_DIST2;
        S_DIST2: state_r <= S_ARRIVE;
        S_ARRIVE: begin
          if (dist_r < {14'b0, radius_r}) begin
            follow_r <= follow_r + 1'b1;
            state_r  <= (follow_r + 1'b1 >= path_len_r) ? S_EMIT : S_IDLE;
          end else begin
            if (asum_add > 33'sd2147483647) begin
              asum_r <= 32'sh7FFF_FFFF;
            end else if (asum_add < -33'sd2147483648) begin
              asum_r <= 32'sh8000_0000;
            end else begin
              asum_r <= 32'(asum_add);
            end
            alast_r <= ae_r;
            if (lsum_add > 49'sh7FFF_FFFF_FFFF) begin
              lsum_r <= 48'sh7FFF_FFFF_FFFF;
            end else begin
              lsum_r <= 48'(lsum_add);
            end
            llast_r <= $signed(le_c);
            mcnt_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 4'd11) begin
            smooth_r <= sm_c[31:16];
            state_r  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      rx_r  <= in_robot_x;
      ry_r  <= in_robot_y;
      yaw_r <= in_robot_yaw;
    end
    prod_r <= prod_c;
    unique case (state_r)
      S_IDLE: begin
        res_lin_r  <= '0;
        res_ang_r  <= '0;
        res_stop_r <= 1'b1;
      end
      S_LOAD: begin
        zero_r <= (dx == '0) && (dy == '0);
        if (x0 < 0) begin
          if (y0 >= 0) begin
            cx_r <= y0;
            cy_r <= -x0;
            cz_r <= pwf_pkg::HALF_PI_Q24;
          end else begin
            cx_r <= -y0;
            cy_r <= x0;
            cz_r <= -pwf_pkg::HALF_PI_Q24;
          end
        end else begin
          cx_r <= x0;
          cy_r <= y0;
          cz_r <= '0;
        end
      end
      S_ROT: begin
        if (!cy_r[XW-1]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_v;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_v;
        end
      end
      S_DIST2: begin
        dist_r <= prod_r[57:24];
        ae_r   <= 16'(err_rnd);
      end
      S_ARRIVE: begin
        aderiv_r <= $signed({ae_r[15], ae_r}) - $signed({alast_r[15], alast_r});
        lderiv_r <= $signed({1'b0, le_c}) - $signed({llast_r[31], llast_r});
        le_r     <= le_c;
        scale_r  <= (turn_s < goal_s) ? turn_s : goal_s;
      end
      S_MUL: begin
        unique case (mcnt_r)
          4'd1, 4'd4, 4'd10: acc_r <= (mcnt_r == 4'd4) ? prod_r : prod_r;
          4'd2: acc_r <= sum_c;
          4'd3: ang_r <= 41'((sum_c + 67'sd4096) >>> 13);
          4'd5: acc_r <= acc_r + ip_c;
          4'd6: lin_r <= 42'(lin_c);
          4'd8: begin
            if (absae > 15'd4096) begin
              linq_r <= '0;
              if (ang_r > 41'(pwf_pkg::TURN_WIDE)) begin
                angq_r <= pwf_pkg::TURN_WIDE;
              end else if (ang_r < -41'(pwf_pkg::TURN_WIDE)) begin
                angq_r <= -pwf_pkg::TURN_WIDE;
              end else begin
                angq_r <= 13'(ang_r);
              end
            end else begin
              if (linq_c < 67'sd901) begin
                linq_r <= 11'd901;
              end else if (linq_c > 67'sd1434) begin
                linq_r <= 11'd1434;
              end else begin
                linq_r <= 11'(linq_c);
              end
              if (ang_r > 41'(pwf_pkg::TURN_NARROW)) begin
                angq_r <= pwf_pkg::TURN_NARROW;
              end else if (ang_r < -41'(pwf_pkg::TURN_NARROW)) begin
                angq_r <= -pwf_pkg::TURN_NARROW;
              end else begin
                angq_r <= 13'(ang_r);
              end
            end
          end
          4'd11: begin
            res_lin_r  <= sm_c[26:16];
            res_ang_r  <= angq_r;
            res_stop_r <= 1'b0;
          end
          default: ;
        endcase
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_linear_speed     <= res_lin_r;
          out_angular_rate     <= res_ang_r;
          out_stop_issued      <= res_stop_r;
          out_current_waypoint <= follow_r;
        end
      end
      default: ;
    endcase
  end

  a_follow_bound: assert property (@(posedge clk) disable iff (!rst_n)
    follow_r <= path_len_r) else $error("follow index beyond path length");
  a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= path_len_r) else $error("write pointer beyond path length");
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stop_issued |-> out_linear_speed == '0 && out_angular_rate == '0)
    else $error("stop word carries a nonzero command");
  a_turn_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stop_issued |->
      out_angular_rate <= pwf_pkg::TURN_WIDE && out_angular_rate >= -pwf_pkg::TURN_WIDE)
    else $error("turn rate beyond its limit");

endmodule
